// ===== sv/sas_pkg.sv =====
// sas_pkg: shared types and constants for the sorted address set
// holds the request/result word structs, the controller states and cell controls
// no dependencies
package sas_pkg;

    localparam int ADDR_W       = 32;
    localparam int ENTRY_CNT_W  = 7;
    // fan-in of one step of the match reduction, as a power of two
    localparam int FOLD_LOG_FAN = 3;

    localparam logic KIND_SEARCH = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    // request word
    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] ip_address;
    } t_sas_in;

    // result word
    typedef struct packed {
        logic                   success;
        logic                   set_full;
        logic [ENTRY_CNT_W-1:0] entry_count;
    } t_sas_out;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_FOLD,
        ST_DONE
    } t_sas_state;

    // controls broadcast to every cell of the chain
    typedef struct packed {
        logic cmp_en;
        logic shift_en;
    } t_cell_ctl;

endpackage

// ===== sv/sas_cell.sv =====
// sas_cell: one slot of the sorted chain
// compares its entry against the key and shifts in from its left neighbor on insert
// depends on sas_pkg
module sas_cell
    import sas_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [ADDR_W-1:0] i_key,
    input  logic              i_valid,
    input  logic [ADDR_W-1:0] i_left_entry,
    input  logic              i_left_lt,
    output logic [ADDR_W-1:0] o_entry,
    output logic              o_lt,
    output logic              o_eq
);

    logic [ADDR_W-1:0] r_entry;
    logic              r_lt;

    // stored entry below the key, captured in the compare cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
        end else if (i_ctl.cmp_en) begin
            r_lt <= i_valid && (r_entry < i_key);
        end
    end

    // insert: keep if below key, take key at the landing slot, else shift right
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_en && !r_lt) begin
            r_entry <= i_left_lt ? i_key : i_left_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    assign o_eq    = i_valid && (r_entry == i_key);

endmodule

// ===== sv/sas_or_fold.sv =====
// sas_or_fold: registered reduction of the per-cell match flags
// folds the vector by the package fan-in once per cycle, bit 0 ends as the or
// depends on sas_pkg
module sas_or_fold
    import sas_pkg::*;
#(
    parameter int IN_W  = 64,
    parameter int STEPS = 2
) (
    input  logic            i_clk,
    input  logic            i_load,
    input  logic [IN_W-1:0] i_vec,
    output logic            o_any
);

    localparam int FAN   = 1 << FOLD_LOG_FAN;
    localparam int PAD_W = 1 << (FOLD_LOG_FAN * STEPS);

    logic [PAD_W-1:0] r_vec;
    logic [PAD_W-1:0] n_vec;

    // load the flags, or or each group of FAN bits into one
    always_comb begin
        n_vec = '0;
        for (int i = 0; i < PAD_W / FAN; i++) begin
            n_vec[i] = |r_vec[i*FAN +: FAN];
        end
        if (i_load) begin
            n_vec = PAD_W'(i_vec);
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
    end

    assign o_any = r_vec[0];

endmodule

// ===== sv/sorted_address_set.sv =====
// sorted_address_set: ascending, duplicate-free set of ipv4 addresses
// built from a chain of sas_cell slots and the sas_or_fold match reduction
// depends on sas_pkg, sas_cell, sas_or_fold
//
// usage:
//   a request word (kind, ip_address) is taken at a clock edge where start is
//   high and busy is low. a search byte-swaps its network-order address and
//   reports whether it is stored; an insert adds a host-order address in
//   sorted place, or reports a duplicate, or raises set_full when CAPACITY
//   entries are already held. every request gives one result word on o_result,
//   valid for exactly one cycle while o_strobe is high; the receiver cannot
//   stall, so the word must be taken in that cycle.
//   sequence: a compare state, then the fold states that reduce the match
//   flags, then a decide state; the strobe rises in the cycle where busy
//   falls, so no new request is taken until the result word of the last
//   one appears. the reduction depth of the match tree sets the number of
//   fold states.
//   reset empties the set (count zero) and drops any request in flight; the
//   slot contents are not cleared, slots beyond the count are never matched.
module sorted_address_set
    import sas_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_sas_in  i_item,
    output logic     busy,
    output logic     o_strobe,
    output t_sas_out o_result
);

    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int FOLD_STEPS = ($clog2(CAPACITY) + FOLD_LOG_FAN - 1) / FOLD_LOG_FAN;
    localparam int FC_W       = $clog2(FOLD_STEPS + 1);

    t_sas_state        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [FC_W-1:0]   r_fold_cnt, n_fold_cnt;
    logic [ADDR_W-1:0] r_key, n_key;
    logic              r_kind, n_kind;
    logic              r_strobe, n_strobe;
    t_sas_out          r_result, n_result;

    t_cell_ctl         w_ctl;
    logic              w_fold_load;
    logic              w_found;
    logic              w_full;
    logic [ADDR_W-1:0] w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_eq;
    logic [CAPACITY-1:0] w_valid;

    // chain of slots, each fed by its left neighbor, the head slot by the key
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_valid[g] = CNT_W'(g) < r_count;
        if (g == 0) begin : g_head
            sas_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_key        (r_key),
                .i_valid      (w_valid[g]),
                .i_left_entry (r_key),
                .i_left_lt    (1'b1),
                .o_entry      (w_entry[g]),
                .o_lt         (w_lt[g]),
                .o_eq         (w_eq[g])
            );
        end else begin : g_body
            sas_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_key        (r_key),
                .i_valid      (w_valid[g]),
                .i_left_entry (w_entry[g-1]),
                .i_left_lt    (w_lt[g-1]),
                .o_entry      (w_entry[g]),
                .o_lt         (w_lt[g]),
                .o_eq         (w_eq[g])
            );
        end
    end

    // any slot matching the key
    sas_or_fold #(
        .IN_W  (CAPACITY),
        .STEPS (FOLD_STEPS)
    ) u_fold (
        .i_clk  (i_clk),
        .i_load (w_fold_load),
        .i_vec  (w_eq),
        .o_any  (w_found)
    );

    assign w_full = r_count == CNT_W'(CAPACITY);

    // controller: next state, slot controls and result
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_fold_cnt   = r_fold_cnt;
        n_key        = r_key;
        n_kind       = r_kind;
        n_strobe     = 1'b0;
        n_result     = r_result;
        w_ctl        = '0;
        w_fold_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_kind = i_item.kind;
                    if (i_item.kind == KIND_SEARCH) begin
                        n_key = {i_item.ip_address[7:0], i_item.ip_address[15:8],
                                 i_item.ip_address[23:16], i_item.ip_address[31:24]};
                    end else begin
                        n_key = i_item.ip_address;
                    end
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                w_ctl.cmp_en = 1'b1;
                w_fold_load  = 1'b1;
                n_fold_cnt   = '0;
                n_state      = ST_FOLD;
            end
            ST_FOLD: begin
                n_fold_cnt = r_fold_cnt + 1'b1;
                if (r_fold_cnt == FC_W'(FOLD_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_result.success  = 1'b0;
                n_result.set_full = 1'b0;
                if (r_kind == KIND_SEARCH) begin
                    n_result.success = w_found;
                end else if (!w_found) begin
                    if (w_full) begin
                        n_result.set_full = 1'b1;
                    end else begin
                        w_ctl.shift_en   = 1'b1;
                        n_count          = r_count + 1'b1;
                        n_result.success = 1'b1;
                    end
                end
                n_result.entry_count = ENTRY_CNT_W'(n_count);
                n_strobe = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_fold_cnt <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_fold_cnt <= n_fold_cnt;
            r_strobe   <= n_strobe;
        end
    end

    // key and result word
    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_kind   <= n_kind;
        r_result <= n_result;
    end

    assign busy     = r_state != ST_IDLE;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== sv/sas_checker.sv =====
// sas_checker: port-level checks for sorted_address_set, bound to the top level
// watches the request handshake and the result strobe over time
// depends on sas_pkg and sorted_address_set
module sas_checker
    import sas_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input logic     o_strobe,
    input t_sas_out o_result
);

    // an accepted request word makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request word accepted without going busy");

    // a result word only follows a request in progress
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result word without a request in progress");

    // one request, one single-cycle result word
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    // a refused insert never reports success
    a_full_not_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.set_full) |-> !o_result.success)
        else $error("set_full together with success");

    // count never exceeds the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((CAPACITY > 127) || (o_result.entry_count <= ENTRY_CNT_W'(CAPACITY))))
        else $error("entry count above capacity");

endmodule

bind sorted_address_set sas_checker #(.CAPACITY(CAPACITY)) u_sas_checker (.*);

// ===== dv/tb_sorted_address_set.sv =====
// tb_sorted_address_set: self-checking bench for the sorted address set
// drives search/insert words, tracks the expected set in a class, checks each result word
// depends on sas_pkg and sorted_address_set
module tb_sorted_address_set import sas_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SET_CAPACITY = 64;
    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned CYCLE_LIMIT  = 100000;
    localparam int unsigned IDLE_PCT     = 18;

    // tracks the stored addresses and the result words still owed by the block
    class addr_set_tracker;
        int unsigned       capacity;
        logic [ADDR_W-1:0] mirror_entries[$];
        t_sas_out          pending_results[$];
        int unsigned       error_count;
        int unsigned       searches;
        int unsigned       search_hits;
        int unsigned       added;
        int unsigned       duplicates;
        int unsigned       refusals;

        function new(int unsigned cap);
            capacity = cap;
        endfunction

        static function logic [ADDR_W-1:0] byte_swap(logic [ADDR_W-1:0] v);
            return {v[7:0], v[15:8], v[23:16], v[31:24]};
        endfunction

        function bit holds(logic [ADDR_W-1:0] a);
            foreach (mirror_entries[i]) begin
                if (mirror_entries[i] == a) return 1'b1;
            end
            return 1'b0;
        endfunction

        // work out the result of an accepted word and update the mirrored set
        function void note_request(t_sas_in w);
            logic [ADDR_W-1:0] key;
            int unsigned       pos;
            bit                present;
            t_sas_out          exp;
            key = (w.kind == KIND_SEARCH) ? byte_swap(w.ip_address) : w.ip_address;
            pos = 0;
            while (pos < mirror_entries.size() && mirror_entries[pos] < key) pos++;
            present = (pos < mirror_entries.size()) && (mirror_entries[pos] == key);
            exp = '0;
            if (w.kind == KIND_SEARCH) begin
                searches++;
                exp.success = present;
                if (present) search_hits++;
            end else if (present) begin
                duplicates++;
            end else if (mirror_entries.size() >= capacity) begin
                exp.set_full = 1'b1;
                refusals++;
            end else begin
                mirror_entries.insert(pos, key);
                exp.success = 1'b1;
                added++;
            end
            exp.entry_count = ENTRY_CNT_W'(mirror_entries.size());
            pending_results.push_back(exp);
        endfunction

        // compare a result word against the oldest expectation
        function void check_result(t_sas_out got);
            t_sas_out exp;
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result word, expected none, actual %h", $time, got);
                return;
            end
            exp = pending_results.pop_front();
            if (got.success !== exp.success) begin
                error_count++;
                $display("%0t: success mismatch, expected %0b actual %0b",
                         $time, exp.success, got.success);
            end
            if (got.set_full !== exp.set_full) begin
                error_count++;
                $display("%0t: set_full mismatch, expected %0b actual %0b",
                         $time, exp.set_full, got.set_full);
            end
            if (got.entry_count !== exp.entry_count) begin
                error_count++;
                $display("%0t: entry_count mismatch, expected %0d actual %0d",
                         $time, exp.entry_count, got.entry_count);
            end
        endfunction
    endclass

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_sas_in  i_item  = '0;
    logic     busy;
    logic     o_strobe;
    t_sas_out o_result;

    addr_set_tracker tracker = new(SET_CAPACITY);
    bit              idle_on = 1'b1;
    int unsigned     cycle_count = 0;

    sorted_address_set #(
        .CAPACITY(SET_CAPACITY)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // take every strobed result word
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) tracker.check_result(o_result);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // offer one word, with random gaps, and hold it until busy is low at an edge
    task automatic send_word(logic kind, logic [ADDR_W-1:0] addr);
        t_sas_in w;
        w.kind       = kind;
        w.ip_address = addr;
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        tracker.note_request(w);
    endtask

    // stop sending until every owed result word has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [ADDR_W-1:0] pick_stored();
        if (tracker.mirror_entries.size() == 0) return $urandom();
        return tracker.mirror_entries[$urandom_range(0, tracker.mirror_entries.size() - 1)];
    endfunction

    // host-order address: duplicates, neighbors of stored ones, extremes, anything
    function automatic logic [ADDR_W-1:0] insert_addr();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return pick_stored();
        if (sel < 70) return $urandom_range(0, 1) ? pick_stored() + 1 : pick_stored() - 1;
        if (sel < 78) return ADDR_W'($urandom_range(0, 15));
        if (sel < 84) return 32'hFFFF_FFFF - ADDR_W'($urandom_range(0, 15));
        return $urandom();
    endfunction

    // network-order address: mostly hits, plus wrong byte order and near misses
    function automatic logic [ADDR_W-1:0] search_addr();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return addr_set_tracker::byte_swap(pick_stored());
        if (sel < 65) return pick_stored();
        if (sel < 80) return addr_set_tracker::byte_swap(pick_stored() + 1);
        return $urandom();
    endfunction

    initial begin
        logic [ADDR_W-1:0] fresh;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty set, extremes, byte order, sorted placement, duplicates
        send_word(KIND_SEARCH, 32'h0000_0000);
        send_word(KIND_INSERT, 32'h0000_0000);
        send_word(KIND_INSERT, 32'hFFFF_FFFF);
        send_word(KIND_INSERT, 32'h0000_0000);
        send_word(KIND_SEARCH, 32'hFFFF_FFFF);
        send_word(KIND_SEARCH, 32'h0000_0000);
        send_word(KIND_INSERT, 32'h0A00_0001);
        send_word(KIND_SEARCH, 32'h0100_000A);
        send_word(KIND_SEARCH, 32'h0A00_0001);
        send_word(KIND_INSERT, 32'h8000_0000);
        send_word(KIND_INSERT, 32'h7FFF_FFFF);
        send_word(KIND_INSERT, 32'h8000_0001);
        send_word(KIND_SEARCH, 32'h0000_0080);
        send_word(KIND_INSERT, 32'hFFFF_FFFF);
        send_word(KIND_INSERT, 32'h0000_0001);
        send_word(KIND_SEARCH, 32'h1234_5678);
        send_word(KIND_SEARCH, 32'hFFFF_FF7F);
        drain();

        // random mix; the set fills part way through
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_on = !(n >= 300 && n < 450);
            if (n == 500) drain();
            if ($urandom_range(0, 99) < 35) send_word(KIND_INSERT, insert_addr());
            else send_word(KIND_SEARCH, search_addr());
        end
        idle_on = 1'b1;

        // fill to capacity, then new, duplicate and search words on a full set
        while (tracker.mirror_entries.size() < SET_CAPACITY) begin
            do fresh = $urandom(); while (tracker.holds(fresh));
            send_word(KIND_INSERT, fresh);
        end
        do fresh = $urandom(); while (tracker.holds(fresh));
        send_word(KIND_INSERT, fresh);
        send_word(KIND_INSERT, pick_stored());
        send_word(KIND_INSERT, 32'hFFFF_FFFF);
        send_word(KIND_INSERT, 32'h0000_0000);
        send_word(KIND_SEARCH, addr_set_tracker::byte_swap(pick_stored()));
        send_word(KIND_SEARCH, addr_set_tracker::byte_swap(fresh));

        // let the last result words come back
        drain();
        repeat (20) @(posedge i_clk);

        $display("covered %0d searches (%0d found) and inserts: %0d added, %0d duplicate,",
                 tracker.searches, tracker.search_hits, tracker.added, tracker.duplicates);
        $display("%0d refused on a full set of %0d entries, over %0d cycles",
                 tracker.refusals, SET_CAPACITY, cycle_count);
        if (tracker.error_count == 0 && tracker.pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sorted_address_set.f =====
sv/sas_pkg.sv
sv/sas_cell.sv
sv/sas_or_fold.sv
sv/sorted_address_set.sv
sv/sas_checker.sv
dv/tb_sorted_address_set.sv
